[design/pbcd_pkg.sv]
// package for the serial packed-bcd add/subtract block: types, constants, digit functions
`default_nettype none

package pbcd_pkg;

   // padding and overflow extension pairs
   localparam logic [7:0] PAD_NEG = 8'h99;
   localparam logic [7:0] PAD_POS = 8'h00;
   localparam logic [7:0] EXT_NEG = 8'h89;
   localparam logic [7:0] EXT_POS = 8'h10;

   // decimal digit limits
   localparam logic [4:0] DIGIT_MAX = 5'd9;
   localparam logic [4:0] DIGIT_ADJ = 5'd6;
   localparam logic [3:0] NINE      = 4'd9;

   // action codes
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_SUB = 1'b1;

   // one input item as held in the input register
   typedef struct packed {
      logic       action;
      logic [7:0] a_pair;
      logic [7:0] b_pair;
      logic       a_present;
      logic       b_present;
      logic       a_negative;
      logic       b_negative;
      logic       first_pair;
      logic       last_pair;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [7:0] sum_pair;
      logic       result_negative;
      logic       final_pair;
   } rsp_item_type;

   // everything the pair unit produces for one item
   typedef struct packed {
      rsp_item_type first_item;
      rsp_item_type ext_item;
      logic         append;
      logic         carry_out;
   } calc_type;

   // nine's complement of one digit, wrapping for non-decimal nibbles
   function automatic logic [3:0] nine_comp_digit(input logic [3:0] d);
      nine_comp_digit = NINE - d;
   endfunction

   // one decimal digit add with add-6 correction, returns {carry, digit}
   function automatic logic [4:0] digit_add(input logic [3:0] x, input logic [3:0] y,
                                            input logic c);
      logic [4:0] s;
      logic [4:0] adj;
      s   = {1'b0, x} + {1'b0, y} + {4'b0, c};
      adj = s + DIGIT_ADJ;
      if (s > DIGIT_MAX) begin
         digit_add = {1'b1, adj[3:0]};
      end else begin
         digit_add = {1'b0, s[3:0]};
      end
   endfunction

endpackage

`default_nettype wire

[design/pbcd_if.sv]
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface pbcd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] a_pair;
   logic [7:0] b_pair;
   logic       a_present;
   logic       b_present;
   logic       a_negative;
   logic       b_negative;
   logic       first_pair;
   logic       last_pair;

   modport source (output valid, action, a_pair, b_pair, a_present, b_present,
                   a_negative, b_negative, first_pair, last_pair, input ready);
   modport sink   (input valid, action, a_pair, b_pair, a_present, b_present,
                   a_negative, b_negative, first_pair, last_pair, output ready);
endinterface

interface pbcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sum_pair;
   logic       result_negative;
   logic       final_pair;

   modport source (output valid, sum_pair, result_negative, final_pair, input ready);
   modport sink   (input valid, sum_pair, result_negative, final_pair, output ready);
endinterface

`default_nettype wire

[design/packed_bcd_serial_add_sub.sv]
// top level: input register, pair unit with decimal carry, result queue
// a result item passes through the input register and then the result queue before it
// is offered on the result channel
// throughput: one input item per cycle while the result queue has room; an item that overflows yields two result
// items and waits in the input stage until the two-entry result queue is empty
// reset clears the decimal carry, the input valid flag and the result queue
`default_nettype none

module packed_bcd_serial_add_sub
   import pbcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pbcd_req_if.sink   req,
   pbcd_rsp_if.source rsp
);

   req_item_type in_item_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   logic         carry_ff;
   logic         carry_in;
   logic         req_fire;
   logic         advance;
   logic         space_one;
   logic         space_two;
   calc_type     calc;

   // input stage moves on when the queue has room for all its results
   assign advance   = in_valid_ff && (calc.append ? space_two : space_one);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      carry_in    = advance ? calc.carry_out : carry_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         carry_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         carry_ff    <= carry_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.action     <= req.action;
         in_item_ff.a_pair     <= req.a_pair;
         in_item_ff.b_pair     <= req.b_pair;
         in_item_ff.a_present  <= req.a_present;
         in_item_ff.b_present  <= req.b_present;
         in_item_ff.a_negative <= req.a_negative;
         in_item_ff.b_negative <= req.b_negative;
         in_item_ff.first_pair <= req.first_pair;
         in_item_ff.last_pair  <= req.last_pair;
      end
   end

   pbcd_pair_unit u_pair (
      .item     (in_item_ff),
      .carry_ff (carry_ff),
      .calc     (calc)
   );

   pbcd_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .wr_two    (calc.append),
      .wr_item0  (calc.first_item),
      .wr_item1  (calc.ext_item),
      .space_one (space_one),
      .space_two (space_two),
      .rsp       (rsp)
   );

   // checks
   a_accept_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && in_valid_ff) |-> advance)
      else $error("item accepted while input stage held");

   a_carry_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> (carry_ff == $past(calc.carry_out)))
      else $error("decimal carry not updated");

   a_result_offered: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp.valid)
      else $error("no result after item left input stage");

   a_carry_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(carry_ff))
      else $error("decimal carry changed without an item");

endmodule

`default_nettype wire

[design/pbcd_pair_unit.sv]
// combinational pair adder: padding, nine's complement, two digit adds, sign and overflow
`default_nettype none

module pbcd_pair_unit
   import pbcd_pkg::*;
(
   input  req_item_type item,
   input  logic         carry_ff,
   output calc_type     calc
);

   logic       b_neg_eff;
   logic       carry_in;
   logic [7:0] x_pair;
   logic [7:0] y_pair;
   logic [4:0] lo_res;
   logic [4:0] hi_res;
   logic       c_out;
   logic       sign;
   logic       append;
   logic [7:0] ext_pair;

   always_comb begin
      // effective sign of b and the carry into the low digit
      b_neg_eff = item.b_negative ^ item.action;
      carry_in  = item.first_pair ? (item.action == ACT_SUB) : carry_ff;

      // operand a with sign padding
      if (item.a_present) begin
         x_pair = item.a_pair;
      end else begin
         x_pair = item.a_negative ? PAD_NEG : PAD_POS;
      end

      // operand b, complemented on subtract, padding already carries the flipped sign
      if (item.b_present) begin
         if (item.action == ACT_SUB) begin
            y_pair = {nine_comp_digit(item.b_pair[7:4]), nine_comp_digit(item.b_pair[3:0])};
         end else begin
            y_pair = item.b_pair;
         end
      end else begin
         y_pair = b_neg_eff ? PAD_NEG : PAD_POS;
      end

      // upper nibble is the lower-order digit
      lo_res = digit_add(x_pair[7:4], y_pair[7:4], carry_in);
      hi_res = digit_add(x_pair[3:0], y_pair[3:0], lo_res[4]);
      c_out  = hi_res[4];

      // sign and overflow on the last pair
      sign     = 1'b0;
      append   = 1'b0;
      ext_pair = EXT_POS;
      if (item.last_pair) begin
         if (item.a_negative == b_neg_eff) begin
            sign = item.a_negative;
            if (item.a_negative && !c_out) begin
               append   = 1'b1;
               ext_pair = EXT_NEG;
            end else if (!item.a_negative && c_out) begin
               append   = 1'b1;
               ext_pair = EXT_POS;
            end
         end else begin
            sign = !c_out;
         end
      end

      calc.first_item.sum_pair        = {lo_res[3:0], hi_res[3:0]};
      calc.first_item.result_negative = item.last_pair && !append && sign;
      calc.first_item.final_pair      = item.last_pair && !append;
      calc.ext_item.sum_pair          = ext_pair;
      calc.ext_item.result_negative   = sign;
      calc.ext_item.final_pair        = 1'b1;
      calc.append                     = append;
      calc.carry_out                  = c_out;
   end

endmodule

`default_nettype wire

[design/pbcd_rsp_fifo.sv]
// two-entry result queue that takes one or two items per cycle and drives the result channel
`default_nettype none

module pbcd_rsp_fifo
   import pbcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic          wr_two,
   input  rsp_item_type  wr_item0,
   input  rsp_item_type  wr_item1,
   output logic          space_one,
   output logic          space_two,
   pbcd_rsp_if.source    rsp
);

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         pop;
   rsp_item_type head;

   assign pop       = rsp.valid && rsp.ready;
   assign space_one = (count_ff != 2'd2);
   assign space_two = (count_ff == 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff - {1'b0, pop};
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff ^ !wr_two;
         count_in  = count_in + (wr_two ? 2'd2 : 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, second item goes to the other slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item0;
         if (wr_two) begin
            entry_ff[!wr_ptr_ff] <= wr_item1;
         end
      end
   end

   // head of queue onto the result channel
   assign head                = entry_ff[rd_ptr_ff];
   assign rsp.valid           = (count_ff != 2'd0);
   assign rsp.sum_pair        = head.sum_pair;
   assign rsp.result_negative = head.result_negative;
   assign rsp.final_pair      = head.final_pair;

endmodule

`default_nettype wire

[test/tb_packed_bcd_serial_add_sub.sv]
// testbench for the serial packed-bcd add/subtract block: driver, monitor, sum predictor
`timescale 1ns / 100ps

module tb_packed_bcd_serial_add_sub
   import pbcd_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned HOLD_CYCLES = 60;

   // one stimulus item, optionally held back until every result is in
   typedef struct packed {
      req_item_type item;
      logic         drain;
   } pending_pair_type;

   logic clock;
   logic reset;

   pbcd_req_if req_ch ();
   pbcd_rsp_if rsp_ch ();

   packed_bcd_serial_add_sub dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   pending_pair_type pending_pairs [$];
   rsp_item_type     expected_sums [$];

   req_item_type     cur_item;
   pending_pair_type next_entry;
   rsp_item_type     want_item;
   logic             sum_carry;
   int unsigned      error_count;
   int unsigned      cycle_count;
   int unsigned      items_queued;
   int unsigned      items_accepted;
   int unsigned      burst_left;
   int unsigned      gap_left;
   int unsigned      hold_left;
   int unsigned      holds_done;
   int unsigned      stall_mode;
   int unsigned      mode_left;
   logic             ready_next;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // count a mismatch and print it
   task automatic report_error(input string msg);
      $display("[%0d] ERROR: %s", cycle_count, msg);
      error_count++;
   endtask

   // one decimal digit with add-6 correction, returns {carry, digit}
   function automatic logic [4:0] dec_digit_sum(input logic [3:0] x, input logic [3:0] y,
                                                input logic cin);
      logic [4:0] s;
      logic [4:0] t;
      s = {1'b0, x} + {1'b0, y} + {4'b0, cin};
      t = s + 5'd6;
      if (s > 5'd9) begin
         return {1'b1, t[3:0]};
      end
      return {1'b0, s[3:0]};
   endfunction

   // work out the result items of one accepted item and advance the carry
   task automatic predict_bcd_sum(input req_item_type it);
      logic [7:0]   x;
      logic [7:0]   y;
      logic [7:0]   ext;
      logic [4:0]   d;
      logic [3:0]   lo_digit;
      logic         c;
      logic         b_eff;
      logic         sign;
      logic         grow;
      rsp_item_type r;
      b_eff = it.b_negative ^ it.action;
      c     = it.first_pair ? it.action : sum_carry;
      x     = it.a_present ? it.a_pair : (it.a_negative ? PAD_NEG : PAD_POS);
      if (!it.b_present) begin
         y = b_eff ? PAD_NEG : PAD_POS;
      end else if (it.action == ACT_SUB) begin
         y = {4'd9 - it.b_pair[7:4], 4'd9 - it.b_pair[3:0]};
      end else begin
         y = it.b_pair;
      end
      // lower-order digit sits in the upper nibble
      d        = dec_digit_sum(x[7:4], y[7:4], c);
      lo_digit = d[3:0];
      d        = dec_digit_sum(x[3:0], y[3:0], d[4]);
      c        = d[4];
      sum_carry = c;
      sign = 1'b0;
      grow = 1'b0;
      ext  = PAD_POS;
      // sign and overflow extension on the highest pair
      if (it.last_pair) begin
         if (it.a_negative == b_eff) begin
            sign = it.a_negative;
            if (it.a_negative && !c) begin
               grow = 1'b1;
               ext  = EXT_NEG;
            end else if (!it.a_negative && c) begin
               grow = 1'b1;
               ext  = EXT_POS;
            end
         end else begin
            sign = !c;
         end
      end
      r.sum_pair        = {lo_digit, d[3:0]};
      r.result_negative = (it.last_pair && !grow) ? sign : 1'b0;
      r.final_pair      = it.last_pair && !grow;
      expected_sums.push_back(r);
      if (grow) begin
         r.sum_pair        = ext;
         r.result_negative = sign;
         r.final_pair      = 1'b1;
         expected_sums.push_back(r);
      end
   endtask

   function automatic req_item_type make_item(input logic act, input logic [7:0] a,
                                              input logic [7:0] b, input logic ap,
                                              input logic bp, input logic an, input logic bn,
                                              input logic f, input logic l);
      req_item_type it;
      it.action     = act;
      it.a_pair     = a;
      it.b_pair     = b;
      it.a_present  = ap;
      it.b_present  = bp;
      it.a_negative = an;
      it.b_negative = bn;
      it.first_pair = f;
      it.last_pair  = l;
      return it;
   endfunction

   task automatic push_pair(input req_item_type it, input logic drain);
      pending_pair_type e;
      e.item  = it;
      e.drain = drain;
      pending_pairs.push_back(e);
      items_queued++;
   endtask

   // mostly two decimal digits, now and then any byte
   function automatic logic [7:0] rand_pair(input bit raw);
      if (raw) begin
         return 8'($urandom_range(0, 255));
      end
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   // one operation of random lengths; mangle 1 drops the first flag, 2 drops the last flag
   task automatic queue_bcd_op(input int unsigned mangle, input logic drain);
      int unsigned  a_len;
      int unsigned  b_len;
      int unsigned  n;
      bit           raw;
      logic         act;
      logic         a_neg;
      logic         b_neg;
      logic         ap;
      logic         bp;
      req_item_type it;
      a_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      b_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      n     = (a_len > b_len) ? a_len : b_len;
      raw   = ($urandom_range(0, 7) == 0);
      act   = 1'($urandom_range(0, 1));
      a_neg = 1'($urandom_range(0, 1));
      b_neg = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < n; i++) begin
         ap = (i < a_len);
         bp = (i < b_len);
         it = make_item(act, ap ? rand_pair(raw) : 8'($urandom_range(0, 255)),
                        bp ? rand_pair(raw) : 8'($urandom_range(0, 255)),
                        ap, bp, a_neg, b_neg, (i == 0) && (mangle != 1),
                        (i == n - 1) && (mangle != 2));
         push_pair(it, drain && (i == 0));
      end
   endtask

   // stimulus, reset and end of run
   initial begin
      reset            = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_ADD;
      req_ch.a_pair     = 8'h00;
      req_ch.b_pair     = 8'h00;
      req_ch.a_present  = 1'b0;
      req_ch.b_present  = 1'b0;
      req_ch.a_negative = 1'b0;
      req_ch.b_negative = 1'b0;
      req_ch.first_pair = 1'b0;
      req_ch.last_pair  = 1'b0;
      rsp_ch.ready      = 1'b0;
      error_count  = 0;
      items_queued = 0;

      // zero plus zero
      push_pair(make_item(ACT_ADD, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
      // largest decimal pairs, positive overflow
      push_pair(make_item(ACT_ADD, 8'h99, 8'h99, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
      // equal operands subtracted
      push_pair(make_item(ACT_SUB, 8'h99, 8'h99, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
      // negative overflow
      push_pair(make_item(ACT_ADD, 8'h01, 8'h01, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
      // negative minus negative
      push_pair(make_item(ACT_SUB, 8'h25, 8'h47, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
      // positive minus negative overflows through the sign flip
      push_pair(make_item(ACT_SUB, 8'h09, 8'h01, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
      // non-decimal nibbles
      push_pair(make_item(ACT_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
      push_pair(make_item(ACT_SUB, 8'hAB, 8'hCD, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1), 1'b0);
      // shorter negative b is padded
      push_pair(make_item(ACT_ADD, 8'h34, 8'h12, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0), 1'b0);
      push_pair(make_item(ACT_ADD, 8'h56, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0);
      // padded b in a subtraction takes the flipped sign, no complement
      push_pair(make_item(ACT_SUB, 8'h10, 8'h20, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0);
      push_pair(make_item(ACT_SUB, 8'h77, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);
      // shorter negative a is padded
      push_pair(make_item(ACT_ADD, 8'h50, 8'h50, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0), 1'b0);
      push_pair(make_item(ACT_ADD, 8'hFF, 8'h12, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0);
      push_pair(make_item(ACT_ADD, 8'h00, 8'h34, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1), 1'b0);
      // item after the last one without a new first
      push_pair(make_item(ACT_ADD, 8'h11, 8'h22, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);
      // carry rippling through middle pairs
      push_pair(make_item(ACT_SUB, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0);
      push_pair(make_item(ACT_SUB, 8'h99, 8'h99, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
      push_pair(make_item(ACT_SUB, 8'h00, 8'h99, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);
      // both operands padded
      push_pair(make_item(ACT_ADD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
      push_pair(make_item(ACT_SUB, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);

      // random part, pausing after the directed items and for operations queued from item 400 to 403
      queue_bcd_op(0, 1'b1);
      while (items_queued < RANDOM_ITEMS + 21) begin
         case ($urandom_range(0, 9))
            8:       queue_bcd_op($urandom_range(1, 2), 1'b0);
            9:       push_pair(req_item_type'(23'($urandom())), 1'b0);
            default: queue_bcd_op(0, (items_queued >= 400) && (items_queued < 404));
         endcase
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain stimulus, then results, then let the pipeline settle
      while (pending_pairs.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial cycle_count = 0;

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         sum_carry      = 1'b0;
         burst_left     = $urandom_range(1, 16);
         gap_left       = 0;
         items_accepted <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_bcd_sum(cur_item);
            items_accepted <= items_accepted + 1;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // keep offering the same item
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_pairs.size() != 0 &&
                      !(pending_pairs[0].drain && expected_sums.size() != 0)) begin
            next_entry = pending_pairs.pop_front();
            cur_item   = next_entry.item;
            req_ch.valid      <= 1'b1;
            req_ch.action     <= cur_item.action;
            req_ch.a_pair     <= cur_item.a_pair;
            req_ch.b_pair     <= cur_item.b_pair;
            req_ch.a_present  <= cur_item.a_present;
            req_ch.b_present  <= cur_item.b_present;
            req_ch.a_negative <= cur_item.a_negative;
            req_ch.b_negative <= cur_item.b_negative;
            req_ch.first_pair <= cur_item.first_pair;
            req_ch.last_pair  <= cur_item.last_pair;
            if (burst_left <= 1) begin
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: check results against the predicted sums, stall the result side
   always @(posedge clock) begin
      ready_next = 1'b0;
      if (reset) begin
         hold_left  = 0;
         holds_done = 0;
         stall_mode = 0;
         mode_left  = $urandom_range(20, 100);
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_sums.size() == 0) begin
               report_error($sformatf("unexpected result item %h", rsp_ch.sum_pair));
            end else begin
               want_item = expected_sums.pop_front();
               if (rsp_ch.sum_pair !== want_item.sum_pair) begin
                  report_error($sformatf("sum_pair got %h want %h",
                                         rsp_ch.sum_pair, want_item.sum_pair));
               end
               if (rsp_ch.result_negative !== want_item.result_negative) begin
                  report_error($sformatf("result_negative got %b want %b (pair %h)",
                                         rsp_ch.result_negative,
                                         want_item.result_negative, want_item.sum_pair));
               end
               if (rsp_ch.final_pair !== want_item.final_pair) begin
                  report_error($sformatf("final_pair got %b want %b (pair %h)",
                                         rsp_ch.final_pair, want_item.final_pair,
                                         want_item.sum_pair));
               end
            end
         end
         // long hold-off so the block fills and backs up its input
         if (hold_left == 0 && ((holds_done == 0 && items_accepted >= 300) ||
                                (holds_done == 1 && items_accepted >= 650))) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_done + 1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 100);
            end else begin
               mode_left = mode_left - 1;
            end
            case (stall_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 3) != 0);
               default: ready_next = ($urandom_range(0, 9) < 3);
            endcase
         end
      end
      rsp_ch.ready <= ready_next;
   end

endmodule

[files.f]
design/pbcd_pkg.sv
design/pbcd_if.sv
design/pbcd_pair_unit.sv
design/pbcd_rsp_fifo.sv
design/packed_bcd_serial_add_sub.sv
test/tb_packed_bcd_serial_add_sub.sv
